// ===== hdl/fjg_pkg.sv =====
// Shared types, codes and sizing constants of the feeder jam guard and rate control.
package fjg_pkg;

	// Default number of slots per feeder revolution
	localparam int ROUND_SLOTS_DEF = 7;

	// Serial multiplier operand width (16 x 16 -> 32)
	localparam int MUL_W = 16;

	// Serial divider: dividend width and longest quotient
	localparam int DIV_W  = 41;
	localparam int QUO_W  = 24;
	// Quotient bits of the heat interpolation and of the rate-to-speed step
	localparam int RATE_QBITS = 16;
	localparam int TGT_QBITS  = 24;
	// Width of 10 * (slowdown - ceasefire)
	localparam int DEN_W = 20;

	// Jam guard phases
	typedef enum logic [1:0] {
		PH_NORMAL  = 2'd0,
		PH_SUSPECT = 2'd1,
		PH_CONFIRM = 2'd2,
		PH_PROCESS = 2'd3
	} phase_t;

	// Fire modes
	typedef enum logic [1:0] {
		MODE_DISABLE = 2'd0,
		MODE_CEASE   = 2'd1,
		MODE_SPOT    = 2'd2,
		MODE_AUTO    = 2'd3
	} fire_mode_t;

	// Feeder drive methods
	typedef enum logic [1:0] {
		M_CURRENT = 2'd0,
		M_SPEED   = 2'd1,
		M_ANGLE   = 2'd2
	} method_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_MUL    = 3'd1,
		ST_SUM    = 3'd2,
		ST_SAT    = 3'd3,
		ST_RDIV   = 3'd4,
		ST_TSTART = 3'd5,
		ST_TDIV   = 3'd6,
		ST_DONE   = 3'd7
	} seq_state_t;

	// Configuration register indexes
	typedef logic [2:0] cfg_addr_t;
	localparam cfg_addr_t REG_TORQUE_THRESHOLD = 3'd0;
	localparam cfg_addr_t REG_SUSPECT_TICKS    = 3'd1;
	localparam cfg_addr_t REG_SOLVE_TICKS      = 3'd2;
	localparam cfg_addr_t REG_BACK_ANGLE       = 3'd3;
	localparam cfg_addr_t REG_FRICTION_SPEED   = 3'd4;
	localparam cfg_addr_t REG_TARGET_RATE      = 3'd5;
	localparam cfg_addr_t REG_SLOWDOWN_MARGIN  = 3'd6;
	localparam cfg_addr_t REG_CEASEFIRE_MARGIN = 3'd7;

endpackage

// ===== hdl/fjg_mul.sv =====
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module fjg_mul #(
	parameter int W = fjg_pkg::MUL_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic           done,
	output logic [2*W-1:0] prod
);

	localparam int CW = $clog2(W + 1);

	logic           busy_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [2*W-1:0] a_q;
	logic [W-1:0]   b_q;
	logic [2*W-1:0] acc_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: add shifted multiplicand when the low multiplier bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= (2*W)'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== hdl/fjg_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle against a pre-aligned divisor.
module fjg_div #(
	parameter int DW = fjg_pkg::DIV_W,
	parameter int QW = fjg_pkg::QUO_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DW-1:0]            dividend,
	// divisor shifted left by qbits-1; dividend must stay below divisor << qbits
	input  logic [DW-1:0]            divisor_al,
	input  logic [$clog2(QW+1)-1:0]  qbits,
	output logic                     done,
	output logic [QW-1:0]            quotient
);

	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsh_q;
	logic [QW-1:0] quo_q;
	logic          ge;

	assign ge = (rem_q >= dsh_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= qbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: trial subtract, shift quotient bit in, move divisor down
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= divisor_al;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/feeder_jam_guard_and_rate_control.sv =====
// Top level: feeder jam guard, fire mode control and heat-limited shot rate.
//
// One input word per control tick gives the motor current and angle, the heat figures and an
// optional fire mode load; one output word per tick gives the feeder drive method and target,
// both friction wheel targets, the guard phase, the shot rate and the fire mode. A tick that
// does not end in auto mode with the guard in normal or suspect skips the serial units. In
// auto mode the rate-to-speed step runs on the serial divider (24 quotient bits); when the heat
// headroom lies between the ceasefire and slowdown margins the interpolation first runs the two
// 16-bit serial multipliers and, unless the rate saturates, a 16-bit division. The serial
// multiplier and divider work one bit per cycle. A result word waits in its output register
// while the next word is taken.
module feeder_jam_guard_and_rate_control #(
	parameter int ROUND_SLOTS = fjg_pkg::ROUND_SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write port
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [23:0]  cfg_wdata,
	// input words
	input  logic         s_tvalid,
	output logic         s_tready,
	// motor_current[15:0], motor_angle[47:16], heat_now[63:48], heat_limit[79:64],
	// heat_cooldown[95:80], mode_write[96], mode_value[98:97], zero fill
	input  logic [103:0] s_tdata,
	// result words
	output logic         m_tvalid,
	input  logic         m_tready,
	// drive_method[1:0], drive_target[33:2], left_wheel_speed[57:34],
	// right_wheel_speed[81:58], jam_phase[83:82], shot_rate[99:84], fire_mode[101:100], zero fill
	output logic [103:0] m_tdata
);

	localparam int DIV_W  = fjg_pkg::DIV_W;
	localparam int QUO_W  = fjg_pkg::QUO_W;
	localparam int DEN_W  = fjg_pkg::DEN_W;
	localparam int MUL_W  = fjg_pkg::MUL_W;
	localparam int DIV_CW = $clog2(QUO_W + 1);
	localparam int RS_HALF = ROUND_SLOTS / 2;
	localparam logic [31:0] SPOT_STEP = 32'((65536 + RS_HALF) / ROUND_SLOTS);
	localparam logic [DIV_W-1:0] TGT_DIV_AL =
		DIV_W'(ROUND_SLOTS) << (fjg_pkg::TGT_QBITS - 1);

	// configuration registers
	logic signed [15:0] thr_q;
	logic [15:0]        suspect_q;
	logic [15:0]        solve_q;
	logic [15:0]        back_q;
	logic [23:0]        fric_q;
	logic [15:0]        trate_q;
	logic [15:0]        slow_q;
	logic [15:0]        cease_q;

	// tick state
	fjg_pkg::phase_t     phase_q;
	logic [15:0]         phase_ticks_q;
	fjg_pkg::fire_mode_t mode_q;
	fjg_pkg::method_t    method_q;
	logic [31:0]         target_q;
	logic [23:0]         wheel_q;
	logic [15:0]         rate_q;

	fjg_pkg::seq_state_t state_q, state_nx;

	// input fields
	logic signed [15:0] in_current;
	logic [31:0]        in_angle;
	logic [15:0]        in_heat_now;
	logic [15:0]        in_heat_limit;
	logic [15:0]        in_cooldown;
	logic               in_mode_write;
	logic [1:0]         in_mode_value;

	assign in_current    = s_tdata[15:0];
	assign in_angle      = s_tdata[47:16];
	assign in_heat_now   = s_tdata[63:48];
	assign in_heat_limit = s_tdata[79:64];
	assign in_cooldown   = s_tdata[95:80];
	assign in_mode_write = s_tdata[96];
	assign in_mode_value = s_tdata[98:97];

	logic accept;
	logic out_free;
	logic out_load;
	logic m_tvalid_q;
	logic [103:0] m_tdata_q;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// guard and mode decision for the word on the input
	fjg_pkg::phase_t     g_phase;
	logic [15:0]         g_ticks;
	logic [15:0]         ticks_inc;
	fjg_pkg::fire_mode_t g_mode;
	fjg_pkg::fire_mode_t mode_eff;
	fjg_pkg::method_t    g_method;
	logic [31:0]         g_target;
	logic [23:0]         g_wheel;
	logic [15:0]         g_rate;
	logic                auto_go;
	logic                high_cur;

	// heat headroom bands
	logic signed [16:0] heat_d;
	logic               band_hi;
	logic               band_mid;
	logic [15:0]        d_minus_c;
	logic [15:0]        s_minus_d;
	logic [15:0]        s_minus_c;

	assign heat_d    = signed'({1'b0, in_heat_limit}) - signed'({1'b0, in_heat_now});
	assign band_hi   = (heat_d >= signed'({1'b0, slow_q}));
	assign band_mid  = !band_hi && (heat_d >= signed'({1'b0, cease_q}));
	assign d_minus_c = heat_d[15:0] - cease_q;
	assign s_minus_d = slow_q - heat_d[15:0];
	assign s_minus_c = slow_q - cease_q;

	assign high_cur  = (in_current >= thr_q);
	assign ticks_inc = (phase_ticks_q == 16'hFFFF) ? phase_ticks_q : phase_ticks_q + 16'd1;
	assign mode_eff  = in_mode_write ? fjg_pkg::fire_mode_t'(in_mode_value) : mode_q;

	always_comb begin
		g_phase  = phase_q;
		g_ticks  = ticks_inc;
		g_mode   = mode_eff;
		g_method = method_q;
		g_target = target_q;
		g_wheel  = wheel_q;
		g_rate   = rate_q;
		auto_go  = 1'b0;
		// jam guard
		case (phase_q)
			fjg_pkg::PH_NORMAL: begin
				if (high_cur) begin
					g_phase = fjg_pkg::PH_SUSPECT;
					g_ticks = '0;
				end
			end
			fjg_pkg::PH_SUSPECT: begin
				if (ticks_inc >= suspect_q) begin
					g_phase = fjg_pkg::PH_CONFIRM;
					g_ticks = '0;
				end else if (!high_cur) begin
					g_phase = fjg_pkg::PH_NORMAL;
					g_ticks = '0;
				end
			end
			fjg_pkg::PH_CONFIRM: begin
				g_method = fjg_pkg::M_ANGLE;
				g_target = in_angle - 32'(back_q);
				g_phase  = fjg_pkg::PH_PROCESS;
				g_ticks  = '0;
			end
			default: begin
				if (ticks_inc >= solve_q) begin
					g_phase = fjg_pkg::PH_NORMAL;
					g_ticks = '0;
				end
			end
		endcase
		// fire mode acts only while the guard is clear
		if (g_phase inside {fjg_pkg::PH_NORMAL, fjg_pkg::PH_SUSPECT}) begin
			case (mode_eff)
				fjg_pkg::MODE_DISABLE: begin
					g_method = fjg_pkg::M_CURRENT;
					g_target = '0;
					g_wheel  = '0;
				end
				fjg_pkg::MODE_CEASE: begin
					g_rate  = '0;
					if (method_q == fjg_pkg::M_SPEED) begin
						g_target = '0;
					end
					g_wheel = fric_q;
				end
				fjg_pkg::MODE_SPOT: begin
					g_method = fjg_pkg::M_ANGLE;
					g_target = in_angle + SPOT_STEP;
					g_wheel  = fric_q;
					g_mode   = fjg_pkg::MODE_CEASE;
				end
				default: begin
					g_method = fjg_pkg::M_SPEED;
					g_wheel  = fric_q;
					g_rate   = band_hi ? trate_q : 16'd0;
					auto_go  = 1'b1;
				end
			endcase
		end
	end

	// serial units
	logic                 mul_start;
	logic                 mul_done;
	logic                 mul2_done;
	logic [2*MUL_W-1:0]   prod_rate;
	logic [2*MUL_W-1:0]   prod_cool;
	logic                 div_start;
	logic                 div_done;
	logic [DIV_W-1:0]     div_dividend;
	logic [DIV_W-1:0]     div_divisor;
	logic [DIV_CW-1:0]    div_qbits;
	logic [QUO_W-1:0]     div_quo;

	logic [DIV_W-1:0]     numr_q;
	logic [DEN_W-1:0]     den_q;
	logic                 sat;
	logic [DIV_W-1:0]     num_sum;

	fjg_mul #(.W(MUL_W)) u_mul_rate (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (trate_q),
		.b      (d_minus_c),
		.done   (mul_done),
		.prod   (prod_rate)
	);

	fjg_mul #(.W(MUL_W)) u_mul_cool (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (in_cooldown),
		.b      (s_minus_d),
		.done   (mul2_done),
		.prod   (prod_cool)
	);

	fjg_div #(.DW(DIV_W), .QW(QUO_W)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.dividend   (div_dividend),
		.divisor_al (div_divisor),
		.qbits      (div_qbits),
		.done       (div_done),
		.quotient   (div_quo)
	);

	// 10*tr*(d-c) + 256*cool*(s-d), plus half the divisor for rounding
	assign num_sum = (DIV_W'(prod_rate) << 3) + (DIV_W'(prod_rate) << 1)
		+ (DIV_W'(prod_cool) << 8) + DIV_W'(den_q >> 1);
	assign sat = (numr_q >= (DIV_W'(den_q) << fjg_pkg::RATE_QBITS));

	// divider operands: heat interpolation in ST_SAT, rate to speed otherwise
	always_comb begin
		if (state_q == fjg_pkg::ST_SAT) begin
			div_dividend = numr_q;
			div_divisor  = DIV_W'(den_q) << (fjg_pkg::RATE_QBITS - 1);
			div_qbits    = DIV_CW'(fjg_pkg::RATE_QBITS);
		end else begin
			div_dividend = DIV_W'({rate_q, 8'd0}) + DIV_W'(RS_HALF);
			div_divisor  = TGT_DIV_AL;
			div_qbits    = DIV_CW'(fjg_pkg::TGT_QBITS);
		end
	end

	// sequencer next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			fjg_pkg::ST_IDLE: begin
				if (accept) begin
					if (auto_go) begin
						state_nx = band_mid ? fjg_pkg::ST_MUL : fjg_pkg::ST_TSTART;
					end else begin
						state_nx = fjg_pkg::ST_DONE;
					end
				end
			end
			fjg_pkg::ST_MUL:    if (mul_done) state_nx = fjg_pkg::ST_SUM;
			fjg_pkg::ST_SUM:    state_nx = fjg_pkg::ST_SAT;
			fjg_pkg::ST_SAT:    state_nx = sat ? fjg_pkg::ST_TSTART : fjg_pkg::ST_RDIV;
			fjg_pkg::ST_RDIV:   if (div_done) state_nx = fjg_pkg::ST_TSTART;
			fjg_pkg::ST_TSTART: state_nx = fjg_pkg::ST_TDIV;
			fjg_pkg::ST_TDIV:   if (div_done) state_nx = fjg_pkg::ST_DONE;
			fjg_pkg::ST_DONE:   if (out_free) state_nx = fjg_pkg::ST_IDLE;
			default:            state_nx = fjg_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = (state_q == fjg_pkg::ST_IDLE);
		mul_start = (state_q == fjg_pkg::ST_IDLE) && accept && auto_go && band_mid;
		div_start = ((state_q == fjg_pkg::ST_SAT) && !sat)
			|| (state_q == fjg_pkg::ST_TSTART);
		out_load  = (state_q == fjg_pkg::ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fjg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= 16'sd10000;
			suspect_q <= 16'd500;
			solve_q   <= 16'd100;
			back_q    <= 16'd9362;
			fric_q    <= '0;
			trate_q   <= '0;
			slow_q    <= 16'd100;
			cease_q   <= 16'd20;
		end else if (cfg_we) begin
			case (cfg_addr)
				fjg_pkg::REG_TORQUE_THRESHOLD: thr_q     <= cfg_wdata[15:0];
				fjg_pkg::REG_SUSPECT_TICKS:    suspect_q <= cfg_wdata[15:0];
				fjg_pkg::REG_SOLVE_TICKS:      solve_q   <= cfg_wdata[15:0];
				fjg_pkg::REG_BACK_ANGLE:       back_q    <= cfg_wdata[15:0];
				fjg_pkg::REG_FRICTION_SPEED:   fric_q    <= cfg_wdata;
				fjg_pkg::REG_TARGET_RATE:      trate_q   <= cfg_wdata[15:0];
				fjg_pkg::REG_SLOWDOWN_MARGIN:  slow_q    <= cfg_wdata[15:0];
				fjg_pkg::REG_CEASEFIRE_MARGIN: cease_q   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// tick state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= fjg_pkg::PH_NORMAL;
			phase_ticks_q <= '0;
			mode_q        <= fjg_pkg::MODE_DISABLE;
			method_q      <= fjg_pkg::M_SPEED;
			target_q      <= '0;
			wheel_q       <= '0;
			rate_q        <= '0;
		end else begin
			if (accept) begin
				phase_q       <= g_phase;
				phase_ticks_q <= g_ticks;
				mode_q        <= g_mode;
				method_q      <= g_method;
				target_q      <= g_target;
				wheel_q       <= g_wheel;
				rate_q        <= g_rate;
			end
			if (state_q == fjg_pkg::ST_SAT && sat) begin
				rate_q <= 16'hFFFF;
			end
			if (state_q == fjg_pkg::ST_RDIV && div_done) begin
				rate_q <= div_quo[15:0];
			end
			if (state_q == fjg_pkg::ST_TDIV && div_done) begin
				target_q <= 32'(div_quo);
			end
		end
	end

	// interpolation operands
	always_ff @(posedge clk) begin
		if (accept) begin
			den_q <= (DEN_W'(s_minus_c) << 3) + (DEN_W'(s_minus_c) << 1);
		end
		if (state_q == fjg_pkg::ST_SUM) begin
			numr_q <= num_sum;
		end
	end

	// right wheel is the left negated, saturating at the most negative value
	logic [23:0] right_wheel;
	assign right_wheel = (wheel_q == 24'h800000) ? 24'h7FFFFF : (24'd0 - wheel_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {2'b00, mode_q, rate_q, phase_q, right_wheel, wheel_q,
				target_q, method_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a change of guard phase restarts its tick count
	a_phase_ticks_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != $past(phase_q)) |-> (phase_ticks_q == 16'd0))
		else $error("phase changed without clearing its tick count");

	// a confirmed jam always leads to processing with the angle method
	a_confirm_backoff: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == fjg_pkg::PH_CONFIRM) |=>
		(phase_q == fjg_pkg::PH_PROCESS && method_q == fjg_pkg::M_ANGLE))
		else $error("confirmed jam did not back off");

	// both multiplier lanes finish together, and only while the sequencer waits on them
	a_mul_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done == mul2_done) && (!mul_done || state_q == fjg_pkg::ST_MUL))
		else $error("multiplier lanes out of step");

	// divider finishes only in a division state
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == fjg_pkg::ST_RDIV || state_q == fjg_pkg::ST_TDIV))
		else $error("divider finished outside a division state");

	// a loaded result is offered on the next cycle
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("loaded result not offered");

endmodule

// ===== test/feeder_jam_guard_and_rate_control_tb.sv =====
// Testbench: feeder jam guard and rate control, directed table then random ticks, self-checking.
`timescale 1ns / 1ps

module feeder_jam_guard_and_rate_control_tb;
	import fjg_pkg::*;

	localparam int          SLOTS       = ROUND_SLOTS_DEF;
	localparam logic [31:0] SLOT_STEP   = (65536 + SLOTS / 2) / SLOTS;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          HOLD_AT     = 700;
	localparam int          HOLD_CYCLES = 400;
	localparam int          TAIL_CYCLES = 100;
	localparam int          PHASES      = 5;
	localparam int          PHASE_WORDS = 285;

	// One control tick as it enters the block
	typedef struct {
		logic signed [15:0] current;
		logic [31:0]        angle;
		logic [15:0]        heat_now;
		logic [15:0]        heat_limit;
		logic [15:0]        heat_cool;
		logic               mode_wr;
		fire_mode_t         mode_val;
	} tick_in_t;

	// One drive word as it leaves the block
	typedef struct {
		method_t     method;
		logic [31:0] target;
		logic [23:0] left;
		logic [23:0] right;
		phase_t      phase;
		logic [15:0] rate;
		fire_mode_t  mode;
	} drive_t;

	typedef enum bit {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		cfg_addr_t   addr;
		logic [23:0] value;
		tick_in_t    word;
		bit          typed;
		drive_t      want;
	} stim_row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_addr;
	logic [23:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;

	feeder_jam_guard_and_rate_control u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Register copies held by the predictor
	logic signed [15:0] cfg_thr;
	logic [15:0]        cfg_suspect;
	logic [15:0]        cfg_solve;
	logic [15:0]        cfg_back;
	logic signed [23:0] cfg_fric;
	logic [15:0]        cfg_rate;
	logic [15:0]        cfg_slow;
	logic [15:0]        cfg_cease;

	// Guard and drive state held by the predictor
	phase_t             g_phase;
	logic [15:0]        g_ticks;
	fire_mode_t         g_mode;
	method_t            g_method;
	logic [31:0]        g_target;
	logic signed [23:0] g_wheel;
	logic [15:0]        g_rate;

	drive_t    drive_due[$];
	stim_row_t stim_q[$];
	int        fault_count = 0;
	int        cycle_count = 0;
	int        sent_count  = 0;
	int        jam_left    = 0;
	bit        writing     = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic tick_in_t tick(int cur, logic [31:0] ang, int hn, int hl, int cool,
		bit mw, fire_mode_t mv);
		tick_in_t w;
		w.current    = cur[15:0];
		w.angle      = ang;
		w.heat_now   = hn[15:0];
		w.heat_limit = hl[15:0];
		w.heat_cool  = cool[15:0];
		w.mode_wr    = mw;
		w.mode_val   = mv;
		return w;
	endfunction

	function automatic drive_t drive(method_t m, logic [31:0] t, logic [23:0] l, logic [23:0] r,
		phase_t p, logic [15:0] rate, fire_mode_t md);
		drive_t d;
		d.method = m;
		d.target = t;
		d.left   = l;
		d.right  = r;
		d.phase  = p;
		d.rate   = rate;
		d.mode   = md;
		return d;
	endfunction

	function automatic logic [103:0] to_bus(tick_in_t w);
		return {5'd0, w.mode_val, w.mode_wr, w.heat_cool, w.heat_limit, w.heat_now,
			w.angle, w.current};
	endfunction

	function automatic drive_t from_bus(logic [103:0] b);
		return drive(method_t'(b[1:0]), b[33:2], b[57:34], b[81:58], phase_t'(b[83:82]),
			b[99:84], fire_mode_t'(b[101:100]));
	endfunction

	task automatic reset_model();
		cfg_thr     = 16'sd10000;
		cfg_suspect = 16'd500;
		cfg_solve   = 16'd100;
		cfg_back    = 16'd9362;
		cfg_fric    = '0;
		cfg_rate    = '0;
		cfg_slow    = 16'd100;
		cfg_cease   = 16'd20;
		g_phase     = PH_NORMAL;
		g_ticks     = '0;
		g_mode      = MODE_DISABLE;
		g_method    = M_SPEED;
		g_target    = '0;
		g_wheel     = '0;
		g_rate      = '0;
	endtask

	// Heat-limited shot rate for auto mode
	function automatic logic [15:0] heat_rate(tick_in_t w);
		longint d, s, c, num, den, r;
		d = w.heat_limit;
		d = d - w.heat_now;
		s = cfg_slow;
		c = cfg_cease;
		if (d >= s)
			r = cfg_rate;
		else if (d >= c) begin
			num = 10 * longint'(cfg_rate) * (d - c) + 256 * longint'(w.heat_cool) * (s - d);
			den = 10 * (s - c);
			r = (num + den / 2) / den;
		end else
			r = 0;
		return (r > 65535) ? 16'hFFFF : r[15:0];
	endfunction

	// Advances the predicted guard and drive state by one tick
	function automatic drive_t feeder_tick(tick_in_t w);
		longint t;
		logic signed [23:0] right;
		if (w.mode_wr)
			g_mode = w.mode_val;
		if (g_ticks != 16'hFFFF)
			g_ticks = g_ticks + 16'd1;

		// jam guard
		case (g_phase)
			PH_NORMAL: begin
				if (w.current >= cfg_thr) begin
					g_phase = PH_SUSPECT;
					g_ticks = '0;
				end
			end
			PH_SUSPECT: begin
				if (g_ticks >= cfg_suspect) begin
					g_phase = PH_CONFIRM;
					g_ticks = '0;
				end else if (w.current < cfg_thr) begin
					g_phase = PH_NORMAL;
					g_ticks = '0;
				end
			end
			PH_CONFIRM: begin
				g_method = M_ANGLE;
				g_target = w.angle - {16'd0, cfg_back};
				g_phase  = PH_PROCESS;
				g_ticks  = '0;
			end
			default: begin
				if (g_ticks >= cfg_solve) begin
					g_phase = PH_NORMAL;
					g_ticks = '0;
				end
			end
		endcase

		// fire mode drives the feeder only outside jam handling
		if (g_phase == PH_NORMAL || g_phase == PH_SUSPECT) begin
			case (g_mode)
				MODE_DISABLE: begin
					g_method = M_CURRENT;
					g_target = '0;
					g_wheel  = '0;
				end
				MODE_CEASE: begin
					g_rate = '0;
					if (g_method == M_SPEED)
						g_target = '0;
					g_wheel = cfg_fric;
				end
				MODE_SPOT: begin
					g_method = M_ANGLE;
					g_target = w.angle + SLOT_STEP;
					g_wheel  = cfg_fric;
					g_mode   = MODE_CEASE;
				end
				default: begin
					g_rate   = heat_rate(w);
					t        = g_rate;
					t        = (t * 256 + SLOTS / 2) / SLOTS;
					g_method = M_SPEED;
					g_target = t[31:0];
					g_wheel  = cfg_fric;
				end
			endcase
		end

		right = (g_wheel == 24'sh800000) ? 24'sh7FFFFF : -g_wheel;
		return drive(g_method, g_target, g_wheel, right, g_phase, g_rate, g_mode);
	endfunction

	task automatic add_word(tick_in_t w);
		stim_row_t r;
		r.kind  = ROW_WORD;
		r.addr  = REG_TORQUE_THRESHOLD;
		r.value = '0;
		r.word  = w;
		r.typed = 1'b0;
		r.want  = drive(M_CURRENT, '0, '0, '0, PH_NORMAL, '0, MODE_DISABLE);
		stim_q.push_back(r);
	endtask

	task automatic add_checked(tick_in_t w, drive_t want);
		stim_row_t r;
		r.kind  = ROW_WORD;
		r.addr  = REG_TORQUE_THRESHOLD;
		r.value = '0;
		r.word  = w;
		r.typed = 1'b1;
		r.want  = want;
		stim_q.push_back(r);
	endtask

	task automatic add_reg(cfg_addr_t a, logic [23:0] v);
		stim_row_t r;
		r.kind  = ROW_REG;
		r.addr  = a;
		r.value = v;
		r.word  = tick(0, '0, 0, 0, 0, 1'b0, MODE_DISABLE);
		r.typed = 1'b0;
		r.want  = drive(M_CURRENT, '0, '0, '0, PH_NORMAL, '0, MODE_DISABLE);
		stim_q.push_back(r);
	endtask

	// Stops offering words and waits until every expected word has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (drive_due.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(cfg_addr_t a, logic [23:0] v);
		cfg_we    <= 1'b1;
		cfg_addr  <= a;
		cfg_wdata <= v;
		@(posedge clk);
		case (a)
			REG_TORQUE_THRESHOLD: cfg_thr     = v[15:0];
			REG_SUSPECT_TICKS:    cfg_suspect = v[15:0];
			REG_SOLVE_TICKS:      cfg_solve   = v[15:0];
			REG_BACK_ANGLE:       cfg_back    = v[15:0];
			REG_FRICTION_SPEED:   cfg_fric    = v;
			REG_TARGET_RATE:      cfg_rate    = v[15:0];
			REG_SLOWDOWN_MARGIN:  cfg_slow    = v[15:0];
			default:              cfg_cease   = v[15:0];
		endcase
	endtask

	// Offers one word after a random gap; queues its expected drive word on acceptance
	task automatic send_word(tick_in_t w, bit typed, drive_t want);
		int gap;
		drive_t exp_word;
		gap = (((sent_count / 50) % 5) == 4) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= to_bus(w);
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		exp_word = feeder_tick(w);
		drive_due.push_back(typed ? want : exp_word);
		sent_count++;
	endtask

	// Register settings of each random phase
	task automatic settle_regs(int k);
		int thr, slow, cease;
		drain();
		case (k)
			1: begin
				write_reg(REG_TORQUE_THRESHOLD, 24'h007FFF);
				write_reg(REG_SUSPECT_TICKS, 24'h00FFFF);
				write_reg(REG_SOLVE_TICKS, 24'h00FFFF);
				write_reg(REG_BACK_ANGLE, 24'h00FFFF);
				write_reg(REG_FRICTION_SPEED, 24'h7FFFFF);
				write_reg(REG_TARGET_RATE, 24'h00FFFF);
				write_reg(REG_SLOWDOWN_MARGIN, 24'h00FFFF);
				write_reg(REG_CEASEFIRE_MARGIN, 24'h000000);
			end
			2: begin
				write_reg(REG_TORQUE_THRESHOLD, 24'h008000);
				write_reg(REG_SUSPECT_TICKS, 24'h000000);
				write_reg(REG_SOLVE_TICKS, 24'h000000);
				write_reg(REG_BACK_ANGLE, 24'h000000);
				write_reg(REG_FRICTION_SPEED, 24'h800000);
				write_reg(REG_TARGET_RATE, 24'h000000);
				write_reg(REG_SLOWDOWN_MARGIN, 24'h000000);
				write_reg(REG_CEASEFIRE_MARGIN, 24'h000000);
			end
			default: begin
				thr = int'($urandom_range(0, 22000)) - 2000;
				slow = $urandom_range(0, 600);
				// phase 3 keeps the ceasefire margin above the slowdown margin
				cease = (k == 3) ? slow + int'($urandom_range(1, 200)) : $urandom_range(0, slow);
				write_reg(REG_TORQUE_THRESHOLD, thr[23:0]);
				write_reg(REG_SUSPECT_TICKS, $urandom_range(0, 12));
				write_reg(REG_SOLVE_TICKS, $urandom_range(0, 12));
				write_reg(REG_BACK_ANGLE, $urandom_range(0, 65535));
				write_reg(REG_FRICTION_SPEED, $urandom);
				write_reg(REG_TARGET_RATE,
					$urandom_range(0, 1) ? $urandom_range(0, 3000) : $urandom_range(0, 65535));
				write_reg(REG_SLOWDOWN_MARGIN, slow[23:0]);
				write_reg(REG_CEASEFIRE_MARGIN, cease[23:0]);
			end
		endcase
		cfg_we <= 1'b0;
	endtask

	// Random tick: runs of high current against the threshold, heat near the margins
	function automatic tick_in_t random_tick();
		int thr, cur, lo, hi, dd, hn, hl, cap, sel;
		fire_mode_t mv;
		thr = cfg_thr;
		if (jam_left == 0 && $urandom_range(0, 5) == 0) begin
			cap = (cfg_suspect > 30) ? 30 : int'(cfg_suspect);
			jam_left = $urandom_range(1, cap + 4);
		end
		if ($urandom_range(0, 15) == 0)
			cur = $urandom_range(0, 65535);
		else if (jam_left > 0 || thr == -32768)
			cur = thr + int'($urandom_range(0, 32767 - thr));
		else
			cur = -32768 + int'($urandom_range(0, thr + 32767));
		if (jam_left > 0)
			jam_left--;

		hn = $urandom_range(0, 65535);
		if ($urandom_range(0, 3) == 0)
			hl = $urandom_range(0, 65535);
		else begin
			lo = (cfg_slow < cfg_cease) ? int'(cfg_slow) : int'(cfg_cease);
			hi = (cfg_slow < cfg_cease) ? int'(cfg_cease) : int'(cfg_slow);
			dd = lo - 5 + int'($urandom_range(0, hi - lo + 10));
			if ($urandom_range(0, 1))
				hn = $urandom_range(0, 2000);
			hl = hn + dd;
			if (hl < 0)
				hl = 0;
			if (hl > 65535)
				hl = 65535;
		end

		sel = $urandom_range(0, 19);
		if (sel < 3)
			mv = MODE_DISABLE;
		else if (sel < 7)
			mv = MODE_CEASE;
		else if (sel < 12)
			mv = MODE_SPOT;
		else
			mv = MODE_AUTO;
		return tick(cur, $urandom, hn, hl,
			$urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom_range(0, 65535),
			$urandom_range(0, 5) == 0, mv);
	endfunction

	// Result side: random stalls, one long hold-off, compare against the oldest expectation
	initial begin : result_side
		int stall;
		int got;
		drive_t seen;
		drive_t want;
		bit bad;
		m_tready = 1'b0;
		got = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (got == HOLD_AT)
				stall = HOLD_CYCLES;
			else if (((got / 60) % 5) == 2)
				stall = 0;
			else
				stall = $urandom_range(0, 9);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			seen = from_bus(m_tdata);
			got++;
			if (drive_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("ERROR: unexpected word %0d: %h", got, m_tdata);
			end else begin
				want = drive_due.pop_front();
				bad = (seen.method != want.method) || (seen.target != want.target) ||
					(seen.left != want.left) || (seen.right != want.right) ||
					(seen.phase != want.phase) || (seen.rate != want.rate) ||
					(seen.mode != want.mode);
				if (bad) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("ERROR: word %0d exp method=%0d target=%h left=%h right=%h",
							got, want.method, want.target, want.left, want.right);
						$display("       phase=%0d rate=%h mode=%0d", want.phase, want.rate,
							want.mode);
						$display("       got method=%0d target=%h left=%h right=%h",
							seen.method, seen.target, seen.left, seen.right);
						$display("       phase=%0d rate=%h mode=%0d", seen.phase, seen.rate,
							seen.mode);
					end
				end
			end
		end
	end

	// Stimulus side
	initial begin : tick_side
		tick_in_t w;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		reset_model();

		// after reset: disable, ceasefire under current, single shot, threshold edge
		add_checked(tick(0, 32'h0, 0, 0, 0, 1'b0, MODE_DISABLE),
			drive(M_CURRENT, 32'h0, 24'h0, 24'h0, PH_NORMAL, 16'h0, MODE_DISABLE));
		add_checked(tick(-32768, 32'hFFFFFFFF, 0, 0, 0, 1'b1, MODE_CEASE),
			drive(M_CURRENT, 32'h0, 24'h0, 24'h0, PH_NORMAL, 16'h0, MODE_CEASE));
		add_checked(tick(0, 32'h7FFFFFFF, 0, 0, 0, 1'b1, MODE_SPOT),
			drive(M_ANGLE, 32'h80002491, 24'h0, 24'h0, PH_NORMAL, 16'h0, MODE_CEASE));
		add_checked(tick(9999, 32'h0, 0, 0, 0, 1'b0, MODE_DISABLE),
			drive(M_ANGLE, 32'h80002491, 24'h0, 24'h0, PH_NORMAL, 16'h0, MODE_CEASE));
		add_checked(tick(10000, 32'h0, 0, 0, 0, 1'b0, MODE_DISABLE),
			drive(M_ANGLE, 32'h80002491, 24'h0, 24'h0, PH_SUSPECT, 16'h0, MODE_CEASE));
		add_checked(tick(9999, 32'h0, 0, 0, 0, 1'b0, MODE_DISABLE),
			drive(M_ANGLE, 32'h80002491, 24'h0, 24'h0, PH_NORMAL, 16'h0, MODE_CEASE));

		// extremes: lowest threshold, most negative wheel speed, widest heat band
		add_reg(REG_TORQUE_THRESHOLD, 24'h008000);
		add_reg(REG_SUSPECT_TICKS, 24'd2);
		add_reg(REG_SOLVE_TICKS, 24'd1);
		add_reg(REG_BACK_ANGLE, 24'h00FFFF);
		add_reg(REG_FRICTION_SPEED, 24'h800000);
		add_reg(REG_TARGET_RATE, 24'h00FFFF);
		add_reg(REG_SLOWDOWN_MARGIN, 24'h00FFFF);
		add_reg(REG_CEASEFIRE_MARGIN, 24'h000000);
		add_checked(tick(-32768, 32'h0, 0, 65535, 0, 1'b1, MODE_AUTO),
			drive(M_SPEED, 32'd2396709, 24'h800000, 24'h7FFFFF, PH_SUSPECT, 16'hFFFF,
				MODE_AUTO));
		add_word(tick(0, 32'h0, 65535, 0, 65535, 1'b0, MODE_AUTO));
		add_word(tick(0, 32'h0, 0, 0, 0, 1'b0, MODE_AUTO));
		add_word(tick(0, 32'h0, 0, 0, 0, 1'b0, MODE_AUTO));
		add_word(tick(32767, 32'h12345678, 0, 30000, 65535, 1'b0, MODE_AUTO));

		// narrow band: margin edges, negative headroom, mode loads
		add_reg(REG_TORQUE_THRESHOLD, 24'h007FFF);
		add_reg(REG_SUSPECT_TICKS, 24'd0);
		add_reg(REG_SOLVE_TICKS, 24'd0);
		add_reg(REG_BACK_ANGLE, 24'd0);
		add_reg(REG_FRICTION_SPEED, 24'h7FFFFF);
		add_reg(REG_TARGET_RATE, 24'd1000);
		add_reg(REG_SLOWDOWN_MARGIN, 24'd100);
		add_reg(REG_CEASEFIRE_MARGIN, 24'd20);
		add_word(tick(32767, 32'hFFFF0000, 0, 60, 0, 1'b0, MODE_AUTO));
		add_word(tick(0, 32'h0, 0, 20, 1, 1'b0, MODE_AUTO));
		add_word(tick(0, 32'h0, 0, 19, 65535, 1'b0, MODE_AUTO));
		add_word(tick(0, 32'h0, 0, 100, 0, 1'b0, MODE_AUTO));
		add_word(tick(0, 32'h0, 65535, 0, 500, 1'b0, MODE_AUTO));
		add_word(tick(0, 32'h0, 0, 0, 0, 1'b1, MODE_DISABLE));
		add_word(tick(0, 32'h0, 10, 90, 300, 1'b1, MODE_AUTO));
		add_word(tick(0, 32'h0, 0, 0, 0, 1'b1, MODE_CEASE));
		add_word(tick(0, 32'h0, 0, 0, 0, 1'b0, MODE_SPOT));
		add_word(tick(0, 32'hFFFFFFFF, 0, 0, 0, 1'b1, MODE_SPOT));

		// empty band: ceasefire margin above slowdown margin
		add_reg(REG_CEASEFIRE_MARGIN, 24'd200);
		add_word(tick(0, 32'h0, 0, 150, 0, 1'b1, MODE_AUTO));
		add_word(tick(0, 32'h0, 0, 100, 0, 1'b0, MODE_AUTO));
		add_word(tick(0, 32'h0, 0, 250, 0, 1'b0, MODE_AUTO));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (stim_q[i]) begin
			if (stim_q[i].kind == ROW_REG) begin
				if (!writing)
					drain();
				writing = 1'b1;
				write_reg(stim_q[i].addr, stim_q[i].value);
			end else begin
				if (writing)
					cfg_we <= 1'b0;
				writing = 1'b0;
				send_word(stim_q[i].word, stim_q[i].typed, stim_q[i].want);
			end
		end

		// random phases, each under its own register settings
		for (int k = 0; k < PHASES; k++) begin
			settle_regs(k);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				w = random_tick();
				send_word(w, 1'b0, drive(M_CURRENT, '0, '0, '0, PH_NORMAL, '0, MODE_DISABLE));
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0 && drive_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
